@@ sv/wwm_pkg.sv @@
// Package: shared types, constants and codes for the waypoint window manager.
`default_nettype none
package wwm_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int WINDOW_LENGTH = 15;
  localparam int WINDOW_OVERLAP_LEN = 5;
  localparam int ID_WIDTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W = $clog2(WINDOW_LENGTH + 1);
  localparam int CHECK_SPAN = (WINDOW_OVERLAP_LEN >= WINDOW_LENGTH) ? 0
                              : WINDOW_LENGTH - WINDOW_OVERLAP_LEN;
  localparam logic [31:0] HOME_RESET = 32'd17554;
  localparam logic [ID_WIDTH-1:0] FIRST_ID_RESET = ID_WIDTH'(101);

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_COMMIT = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;
  localparam logic [1:0] FUNC_HOME   = 2'd3;

  localparam logic [0:0] REG_HOME     = 1'd0;
  localparam logic [0:0] REG_FIRST_ID = 1'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  entry_index;
    logic [31:0] waypoint_number;
    logic [31:0] successor_number;
    logic [6:0]  entry_count;
    logic [31:0] start_waypoint;
    logic [31:0] reported_waypoint;
  } in_item_t;

  typedef struct packed {
    logic [31:0] command_id;
    logic [31:0] window_start;
    logic [31:0] slot_number;
    logic        slot_valid;
    logic        last_slot;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_item;     // latch input item
    logic tbl_write;     // write table entry
    logic set_plan;      // apply commit (size, head)
    logic clear_plan;
    logic set_home;
    logic set_head_rep;  // head <= reported
    logic start_search;  // begin lookup of cur from index 0
    logic search_step;   // advance index
    logic found_adv;     // cur <= successor, count slot/step
    logic win_begin;     // id, head setup
    logic emit;          // load output register
    logic broken;        // mark chain broken
    logic check_begin;   // cur <= head for check
  } wwm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       load_ok;
    logic       count_zero;
    logic       plan_valid;
    logic       going_home;
    logic       rep_zero;
    logic       rep_is_home;
    logic       search_hit;    // registered entry matches cur
    logic       search_end;    // index reached plan size
    logic       hit_is_rep;    // matched entry equals reported
    logic       chain_ok;
    logic       slot_last;
    logic       check_done;
    logic       out_busy;
  } wwm_sts_t;
endpackage
`default_nettype wire

@@ sv/wwm_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module wwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ sv/wwm_datapath.sv @@
// Datapath: table memory, plan state, search index, window counters, output register.
`default_nettype none
module wwm_datapath import wwm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_item_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire wwm_cmd_t    cmd,
  output wwm_sts_t         sts,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);
  in_item_t             item_r;
  logic [31:0]          home_r;
  logic [ID_WIDTH-1:0]  next_id_r, id_r;
  logic [CNT_W-1:0]     plan_size_r;
  logic                 plan_valid_r, going_home_r;
  logic [31:0]          head_r, cur_r;
  logic [CNT_W-1:0]     idx_r;
  logic [SLOT_W-1:0]    slot_r;
  logic                 chain_ok_r;
  logic [31:0]          num_q, succ_q;
  logic [IDX_W-1:0]     addr;
  logic                 we;
  out_item_t            out_r;
  logic                 out_valid_r;

  assign we = cmd.tbl_write;
  assign addr = we ? item_r.entry_index[IDX_W-1:0] : idx_r[IDX_W-1:0];

  wwm_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_num (
    .clk(clk), .we(we), .addr(addr), .wdata(item_r.waypoint_number), .rdata(num_q));
  wwm_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_succ (
    .clk(clk), .we(we), .addr(addr), .wdata(item_r.successor_number), .rdata(succ_q));

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r <= in_data;
    end
    if (cmd.start_search) begin
      idx_r <= '0;
    end else if (cmd.search_step) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r       <= HOME_RESET;
      next_id_r    <= FIRST_ID_RESET;
      plan_size_r  <= '0;
      plan_valid_r <= 1'b0;
      going_home_r <= 1'b0;
      head_r       <= '0;
      cur_r        <= '0;
      id_r         <= '0;
      slot_r       <= '0;
      chain_ok_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_HOME) begin
        home_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_FIRST_ID) begin
        next_id_r <= ID_WIDTH'(cfg_wdata);
      end
      if (cmd.clear_plan) begin
        plan_valid_r <= 1'b0;
        plan_size_r  <= '0;
      end
      if (cmd.set_plan) begin
        plan_valid_r <= 1'b1;
        plan_size_r  <= (item_r.entry_count > 7'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                        : CNT_W'(item_r.entry_count);
        head_r       <= item_r.start_waypoint;
      end
      if (cmd.set_home) begin
        going_home_r <= 1'b1;
      end
      if (cmd.set_head_rep) begin
        head_r <= item_r.reported_waypoint;
      end
      if (cmd.check_begin) begin
        cur_r  <= head_r;
        slot_r <= '0;
      end
      if (cmd.win_begin) begin
        id_r       <= next_id_r;
        next_id_r  <= next_id_r + 1'b1;
        slot_r     <= '0;
        chain_ok_r <= 1'b1;
        if (going_home_r) begin
          head_r <= home_r;
          cur_r  <= home_r;
        end else begin
          cur_r <= head_r;
        end
      end
      if (cmd.broken) begin
        chain_ok_r <= 1'b0;
      end
      if (cmd.found_adv) begin
        cur_r <= succ_q;
      end
      if (cmd.emit) begin
        out_r.command_id   <= 32'(id_r);
        out_r.window_start <= head_r;
        out_r.slot_number  <= going_home_r ? home_r : (cmd.broken ? 32'd0 : num_q);
        out_r.slot_valid   <= going_home_r | ~cmd.broken;
        out_r.last_slot    <= (slot_r == SLOT_W'(WINDOW_LENGTH - 1));
        out_valid_r        <= 1'b1;
        slot_r             <= slot_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // check steps counted in slot_r
      if (cmd.found_adv && !cmd.emit) begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.func        = item_r.func;
    sts.load_ok     = ({1'b0, item_r.entry_index} < 7'(TABLE_DEPTH));
    sts.count_zero  = (item_r.entry_count == '0);
    sts.plan_valid  = plan_valid_r;
    sts.going_home  = going_home_r;
    sts.rep_zero    = (item_r.reported_waypoint == '0);
    sts.rep_is_home = (item_r.reported_waypoint == home_r);
    sts.search_hit  = (num_q == cur_r);
    sts.search_end  = (idx_r >= plan_size_r);
    sts.hit_is_rep  = (num_q == item_r.reported_waypoint);
    sts.chain_ok    = chain_ok_r;
    sts.slot_last   = (slot_r == SLOT_W'(WINDOW_LENGTH - 1));
    sts.check_done  = (slot_r >= SLOT_W'(CHECK_SPAN));
    sts.out_busy    = out_valid_r & ~out_ready;
  end
endmodule
`default_nettype wire

@@ sv/wwm_ctrl.sv @@
// Controller: sequences loads, commits, reports, lookups and window emission.
`default_nettype none
module wwm_ctrl import wwm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire wwm_sts_t sts,
  output wwm_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;  // RAM address presented, data next cycle
  localparam logic [2:0] S_SLOOK  = 3'd3;  // slot lookup compare
  localparam logic [2:0] S_CLOOK  = 3'd4;  // check lookup compare
  localparam logic [2:0] S_SEMIT  = 3'd5;  // emit without lookup (home/broken)
  localparam logic [2:0] S_WAIT   = 3'd6;  // let last transfer go

  logic [2:0] state_r, state_nxt;
  logic       chk_r, chk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    chk_nxt   = chk_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (sts.func)
          FUNC_LOAD: cmd.tbl_write = sts.load_ok;
          FUNC_COMMIT: begin
            if (sts.count_zero) begin
              cmd.clear_plan = 1'b1;
            end else begin
              cmd.set_plan = 1'b1;
              chk_nxt = 1'b0;
              state_nxt = S_WAIT;  // WAIT then starts the window
            end
          end
          FUNC_REPORT: begin
            if (sts.going_home) begin
              if (!sts.rep_is_home) begin
                chk_nxt = 1'b0;
                state_nxt = S_WAIT;
              end
            end else if (sts.plan_valid && !sts.rep_zero) begin
              cmd.check_begin = 1'b1;
              cmd.start_search = 1'b1;
              chk_nxt = 1'b1;
              state_nxt = (CHECK_SPAN == 0) ? S_CLOOK : S_READ;
            end
          end
          FUNC_HOME: cmd.set_home = 1'b1;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WAIT: begin
        // prior output drained; start window
        if (!sts.out_busy) begin
          cmd.win_begin = 1'b1;
          cmd.start_search = 1'b1;
          chk_nxt = 1'b0;
          state_nxt = S_SEMIT;
        end
      end
      S_SEMIT: begin
        if (sts.going_home || !sts.chain_ok) begin
          if (!sts.out_busy) begin
            cmd.emit = 1'b1;
            cmd.broken = !sts.going_home;
            state_nxt = sts.slot_last ? S_IDLE : S_SEMIT;
          end
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = chk_r ? S_CLOOK : S_SLOOK;
        if (chk_r && sts.check_done) begin
          state_nxt = S_CLOOK;
        end
      end
      S_SLOOK: begin
        if (sts.search_end) begin
          if (!sts.out_busy) begin
            cmd.emit = 1'b1;
            cmd.broken = 1'b1;
            state_nxt = sts.slot_last ? S_IDLE : S_SEMIT;
          end
        end else if (sts.search_hit) begin
          if (!sts.out_busy) begin
            cmd.emit = 1'b1;
            cmd.found_adv = 1'b1;
            cmd.start_search = 1'b1;
            state_nxt = sts.slot_last ? S_IDLE : S_READ;
          end
        end else begin
          cmd.search_step = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_CLOOK: begin
        if (sts.check_done || sts.search_end) begin
          // outside the span: move window to report
          cmd.set_head_rep = 1'b1;
          state_nxt = S_WAIT;
          chk_nxt = 1'b0;
        end else if (sts.search_hit) begin
          if (sts.hit_is_rep) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.found_adv = 1'b1;
            cmd.start_search = 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          cmd.search_step = 1'b1;
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/waypoint_window_manager.sv @@
// Top level: waypoint window manager, controller plus datapath.
//  channel | signals                         | transfer
//  in      | in_valid/in_ready, in_data      | valid & ready
//  out     | out_valid/out_ready, out_data   | valid & ready, 15 per window
//  cfg     | cfg_we, cfg_index, cfg_wdata    | cfg_we
// One item at a time. Each table probe is a RAM read (S_READ) followed by a compare, so a
// window searches the table up to once per slot, and a report can add the check walk of
// up to 10 chained lookups.
// Reset is synchronous; the table is not cleared. An output stall holds the sequencer.
`default_nettype none
module waypoint_window_manager import wwm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  wwm_cmd_t cmd;
  wwm_sts_t sts;

  wwm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd));

  wwm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

`ifndef SYNTHESIS
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && !out_ready)) else $error("result overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_ready) else $error("input taken during window");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.slot_last) |=> in_ready) else $error("window did not end");
`endif
endmodule
`default_nettype wire
